// ===== design/e2q_pkg.sv =====
// e2q_pkg: shared widths, pipeline word types and arithmetic helpers
// for the euler-to-quaternion core; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package e2q_pkg;

  localparam int unsigned AW = 20;                // angle input width
  localparam int unsigned CW = 33;                // cordic x/y/z width, q30
  localparam int unsigned QW = 34;                // product width, q30
  localparam int unsigned SW = 34;                // sum of squares width
  localparam int unsigned SQ_PAD = 28;            // sum scaled by 2^28 before the root
  localparam int unsigned SQ_STEPS = (SW + SQ_PAD) / 2;
  localparam int unsigned ROOT_W = SQ_STEPS;
  localparam int unsigned RW = ROOT_W + 5;        // root remainder width
  localparam int unsigned DEN_W = ROOT_W + 1;

  localparam logic [20:0] FULL_TURN = 21'd184320;
  localparam logic [17:0] HALF_TURN = 18'd92160;
  localparam logic [16:0] QUARTER_TURN = 17'd46080;
  localparam logic [20:0] WRAP_OFFSET = 21'd552960;  // three turns
  localparam logic [41:0] RAD_SCALE = 42'd37480659;
  localparam logic [41:0] RAD_RND = 42'd512;
  localparam logic signed [CW-1:0] CORDIC_INIT = 33'sd652032874;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
    logic                 cneg;
  } cord_t;

  typedef struct packed {
    logic [SW-1:0]          s;
    logic [RW-1:0]          rem;
    logic [ROOT_W-1:0]      root;
    logic [3:0][QW-1:0]     q;
  } sqrt_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [3:0]       neg;
    logic [3:0]       ovf;
    logic             zero;
  } div_ctl_t;

  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
    return $signed({1'b0, ATAN_Q30[idx]});
  endfunction

  // q30 * q30 -> q30 with half-up rounding
  function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    p = p + $signed((2*QW)'(1) << 29);
    return p[QW+29:30];
  endfunction

endpackage
`default_nettype wire

// ===== design/e2q_angle_if.sv =====
// e2q_angle_if: valid/ready channel carrying one word of three euler angles
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface e2q_angle_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] pitch_deg;
  logic signed [19:0] yaw_deg;
  logic signed [19:0] roll_deg;

  modport source (output valid, output pitch_deg, output yaw_deg, output roll_deg,
                  input ready);
  modport sink (input valid, input pitch_deg, input yaw_deg, input roll_deg,
                output ready);
endinterface
`default_nettype wire

// ===== design/e2q_quat_if.sv =====
// e2q_quat_if: valid/ready channel carrying one word of a unit quaternion
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface e2q_quat_if #(parameter int unsigned OW = 18);
  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] scalar_part;
  logic signed [OW-1:0] vec_first;
  logic signed [OW-1:0] vec_second;
  logic signed [OW-1:0] vec_third;

  modport source (output valid, output scalar_part, output vec_first,
                  output vec_second, output vec_third, input ready);
  modport sink (input valid, input scalar_part, input vec_first,
                input vec_second, input vec_third, output ready);
endinterface
`default_nettype wire

// ===== design/e2q_cordic_cell.sv =====
// e2q_cordic_cell: one registered rotation-mode cordic micro-rotation
// depends on e2q_pkg
`timescale 1ns / 1ps
`default_nettype none
module e2q_cordic_cell #(
  parameter int unsigned I = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  e2q_pkg::cord_t c_i,
  output e2q_pkg::cord_t c_o
);
  import e2q_pkg::*;

  logic signed [CW-1:0] xs, ys, at;
  cord_t c_d, c_q;

  always_comb begin
    xs = c_i.x >>> I;
    ys = c_i.y >>> I;
    at = atan_q30(5'(I));
    c_d = c_i;
    if (!c_i.z[CW-1]) begin
      c_d.x = c_i.x - ys;
      c_d.y = c_i.y + xs;
      c_d.z = c_i.z - at;
    end else begin
      c_d.x = c_i.x + ys;
      c_d.y = c_i.y - xs;
      c_d.z = c_i.z + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign c_o = c_q;
endmodule
`default_nettype wire

// ===== design/e2q_sqrt_cell.sv =====
// e2q_sqrt_cell: one registered digit of the restoring square root
// depends on e2q_pkg
`timescale 1ns / 1ps
`default_nettype none
module e2q_sqrt_cell #(
  parameter int unsigned K = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  e2q_pkg::sqrt_t s_i,
  output e2q_pkg::sqrt_t s_o
);
  import e2q_pkg::*;

  localparam int unsigned VW = SW + SQ_PAD;
  localparam int unsigned HI = VW - 1 - 2 * K;

  logic [VW-1:0] v;
  logic [RW-1:0] cur, trial;
  sqrt_t s_d, s_q;

  always_comb begin
    v = {s_i.s, {SQ_PAD{1'b0}}};
    cur = {s_i.rem[RW-3:0], v[HI -: 2]};
    trial = {3'b000, s_i.root, 2'b01};
    s_d = s_i;
    if (cur >= trial) begin
      s_d.rem = cur - trial;
      s_d.root = {s_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      s_d.rem = cur;
      s_d.root = {s_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_d;
    end
  end

  assign s_o = s_q;
endmodule
`default_nettype wire

// ===== design/e2q_div_cell.sv =====
// e2q_div_cell: one registered quotient bit of a four-lane restoring divider
// depends on e2q_pkg
`timescale 1ns / 1ps
`default_nettype none
module e2q_div_cell #(
  parameter int unsigned NW = 51,
  parameter int unsigned QB = 18,
  parameter int unsigned J  = 0
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  e2q_pkg::div_ctl_t      ctl_i,
  input  logic [3:0][NW-1:0]     rem_i,
  input  logic [3:0][QB-1:0]     quo_i,
  output e2q_pkg::div_ctl_t      ctl_o,
  output logic [3:0][NW-1:0]     rem_o,
  output logic [3:0][QB-1:0]     quo_o
);
  import e2q_pkg::*;

  logic [NW-1:0]        trial;
  logic [3:0][NW-1:0]   rem_d, rem_q;
  logic [3:0][QB-1:0]   quo_d, quo_q;
  div_ctl_t             ctl_q;

  always_comb begin
    trial = NW'(ctl_i.den) << J;
    for (int l = 0; l < 4; l++) begin
      if (rem_i[l] >= trial) begin
        rem_d[l] = rem_i[l] - trial;
        quo_d[l] = quo_i[l] | (QB'(1) << J);
      end else begin
        rem_d[l] = rem_i[l];
        quo_d[l] = quo_i[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      ctl_q <= ctl_i;
    end
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign ctl_o = ctl_q;
endmodule
`default_nettype wire

// ===== design/euler_to_unit_quaternion_core.sv =====
// euler_to_unit_quaternion_core: pipelined euler-angle to unit-quaternion
// converter; depends on e2q_pkg, e2q_angle_if, e2q_quat_if and the cell modules
//
// Takes one word of pitch, yaw and roll (signed degrees, 9 fraction bits) per
// clock while the output is not stalled and returns the normalized quaternion,
// scalar part first, in signed fixed point with OUT_FRAC_BITS fraction bits.
// Throughput is one word per cycle unless a result word waits to be taken.
// The result word passes through the three cell chains: the cordic
// micro-rotations, the 31-digit square root and the one-bit-per-cell divider.
// A one-word skid register at the input lets a new word in while the output
// word waits to be taken.
`timescale 1ns / 1ps
`default_nettype none
module euler_to_unit_quaternion_core #(
  parameter int unsigned CORDIC_STAGES = 18,
  parameter int unsigned OUT_FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  e2q_angle_if.sink       angles_i,
  e2q_quat_if.source      quat_o
);
  import e2q_pkg::*;

  localparam int unsigned OW = OUT_FRAC_BITS + 2;
  localparam int unsigned QB = OUT_FRAC_BITS + 2;        // quotient bits
  localparam int unsigned NW = QW + OUT_FRAC_BITS + 1;   // dividend width
  localparam int unsigned NV = 3 + CORDIC_STAGES + 6 + SQ_STEPS + 1 + QB;

  // global advance: the whole pipe moves unless the output word is stuck
  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || quat_o.ready;

  // input skid word
  logic                 skid_vld_q;
  logic signed [AW-1:0] skid_ang_q [3];
  logic signed [AW-1:0] feed_ang [3];
  logic                 feed_vld;

  assign angles_i.ready = !skid_vld_q;
  assign feed_vld = skid_vld_q || angles_i.valid;

  always_comb begin
    if (skid_vld_q) begin
      feed_ang[0] = skid_ang_q[0];
      feed_ang[1] = skid_ang_q[1];
      feed_ang[2] = skid_ang_q[2];
    end else begin
      feed_ang[0] = angles_i.pitch_deg;
      feed_ang[1] = angles_i.yaw_deg;
      feed_ang[2] = angles_i.roll_deg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (en) begin
      skid_vld_q <= 1'b0;
    end else if (angles_i.valid && !skid_vld_q) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && angles_i.valid && !skid_vld_q) begin
      skid_ang_q[0] <= angles_i.pitch_deg;
      skid_ang_q[1] <= angles_i.yaw_deg;
      skid_ang_q[2] <= angles_i.roll_deg;
    end
  end

  // valid bits travel alongside the payload stages
  logic [NV-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], feed_vld};
    end
  end

  // stage 1: reduce each angle into one turn; three turns added first so the
  // sum is never negative, then the whole turns are stripped by compares
  logic [20:0] u_w [3];
  logic [20:0] off_w [3];
  logic [17:0] m0_q [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      u_w[l] = 21'($signed(feed_ang[l]) + $signed(WRAP_OFFSET));
      off_w[l] = '0;
      for (int k = 1; k <= 5; k++) begin
        if (u_w[l] >= 21'(k * 184320)) begin
          off_w[l] = 21'(k * 184320);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        m0_q[l] <= 18'(u_w[l] - off_w[l]);
      end
    end
  end

  // stage 2: upper half turn becomes negative (sine flips), then fold beyond
  // a quarter turn back into range (cosine flips)
  logic [16:0] mag_w [3];
  logic [16:0] fold_w [3];
  logic        hneg_w [3];
  logic        hcneg_w [3];
  logic [15:0] a_q [3];
  logic        neg_q [3];
  logic        cneg_q [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      hneg_w[l] = (m0_q[l] >= HALF_TURN);
      mag_w[l] = hneg_w[l] ? 17'(FULL_TURN - 21'(m0_q[l])) : 17'(m0_q[l]);
      hcneg_w[l] = (mag_w[l] > QUARTER_TURN);
      fold_w[l] = hcneg_w[l] ? 17'(HALF_TURN - 18'(mag_w[l])) : mag_w[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        a_q[l] <= fold_w[l][15:0];
        neg_q[l] <= hneg_w[l];
        cneg_q[l] <= hcneg_w[l];
      end
    end
  end

  // stage 3: degrees to q30 radians, loads the cordic seed
  logic [41:0] zprod_w [3];
  cord_t       cord_in_q [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      zprod_w[l] = 42'(a_q[l]) * RAD_SCALE + RAD_RND;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        cord_in_q[l].x <= CORDIC_INIT;
        cord_in_q[l].y <= '0;
        cord_in_q[l].z <= $signed({1'b0, zprod_w[l][41:10]});
        cord_in_q[l].neg <= neg_q[l];
        cord_in_q[l].cneg <= cneg_q[l];
      end
    end
  end

  // cordic chains, one per angle, one micro-rotation per cell
  cord_t cch [3][CORDIC_STAGES+1];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign cch[l][0] = cord_in_q[l];
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
      e2q_cordic_cell #(.I(k)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .c_i   (cch[l][k]),
        .c_o   (cch[l][k+1])
      );
    end
  end

  // apply the fold signs: index 0 pitch, 1 yaw, 2 roll
  logic signed [QW-1:0] sin_q [3];
  logic signed [QW-1:0] cos_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        sin_q[l] <= cch[l][CORDIC_STAGES].neg ? -QW'(cch[l][CORDIC_STAGES].y)
                                              : QW'(cch[l][CORDIC_STAGES].y);
        cos_q[l] <= cch[l][CORDIC_STAGES].cneg ? -QW'(cch[l][CORDIC_STAGES].x)
                                               : QW'(cch[l][CORDIC_STAGES].x);
      end
    end
  end

  // first product rank: yaw/roll cross terms
  logic signed [QW-1:0] cycr_q, sysr_q, sycr_q, cysr_q, sp1_q, cp1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cycr_q <= mulq(cos_q[1], cos_q[2]);
      sysr_q <= mulq(sin_q[1], sin_q[2]);
      sycr_q <= mulq(sin_q[1], cos_q[2]);
      cysr_q <= mulq(cos_q[1], sin_q[2]);
      sp1_q <= sin_q[0];
      cp1_q <= cos_q[0];
    end
  end

  // second product rank: times pitch sine/cosine
  logic signed [QW-1:0] p_q [8];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= mulq(cp1_q, cycr_q);
      p_q[1] <= mulq(sp1_q, sysr_q);
      p_q[2] <= mulq(sp1_q, cycr_q);
      p_q[3] <= mulq(cp1_q, sysr_q);
      p_q[4] <= mulq(cp1_q, sycr_q);
      p_q[5] <= mulq(sp1_q, cysr_q);
      p_q[6] <= mulq(cp1_q, cysr_q);
      p_q[7] <= mulq(sp1_q, sycr_q);
    end
  end

  // raw quaternion, scalar first
  logic signed [QW-1:0] q_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_q[0] <= p_q[0] + p_q[1];
      q_q[1] <= p_q[2] - p_q[3];
      q_q[2] <= p_q[4] + p_q[5];
      q_q[3] <= p_q[6] - p_q[7];
    end
  end

  // squares, never negative
  logic signed [QW-1:0] sqr_q [4];
  logic signed [QW-1:0] q2_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        sqr_q[l] <= mulq(q_q[l], q_q[l]);
        q2_q[l] <= q_q[l];
      end
    end
  end

  // norm squared seeds the square-root chain
  sqrt_t sqrt_in_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqrt_in_q.s <= SW'(sqr_q[0] + sqr_q[1] + sqr_q[2] + sqr_q[3]);
      sqrt_in_q.rem <= '0;
      sqrt_in_q.root <= '0;
      for (int l = 0; l < 4; l++) begin
        sqrt_in_q.q[l] <= q2_q[l];
      end
    end
  end

  // square-root chain, one root bit per cell
  sqrt_t sch [SQ_STEPS+1];
  assign sch[0] = sqrt_in_q;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    e2q_sqrt_cell #(.K(k)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .s_i   (sch[k]),
      .s_o   (sch[k+1])
    );
  end

  // divider seed: |c| << frac + r over 2r, with overflow pre-check
  logic [ROOT_W-1:0]    root_w;
  logic [DEN_W-1:0]     den_w;
  logic [QW-1:0]        cmag_w [4];
  logic [3:0][NW-1:0]   num_w;
  div_ctl_t             dctl_w;

  always_comb begin
    root_w = sch[SQ_STEPS].root;
    den_w = {root_w, 1'b0};
    dctl_w.den = den_w;
    dctl_w.zero = (root_w == '0);
    for (int l = 0; l < 4; l++) begin
      cmag_w[l] = sch[SQ_STEPS].q[l][QW-1] ? QW'(-$signed(sch[SQ_STEPS].q[l]))
                                            : sch[SQ_STEPS].q[l];
      num_w[l] = (NW'(cmag_w[l]) << OUT_FRAC_BITS) + NW'(root_w);
      dctl_w.neg[l] = sch[SQ_STEPS].q[l][QW-1];
      dctl_w.ovf[l] = (num_w[l] >= (NW'(den_w) << QB));
    end
  end

  div_ctl_t           dctl [QB+1];
  logic [3:0][NW-1:0] drem [QB+1];
  logic [3:0][QB-1:0] dquo [QB+1];
  div_ctl_t           dctl_in_q;
  logic [3:0][NW-1:0] drem_in_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dctl_in_q <= dctl_w;
      drem_in_q <= num_w;
    end
  end

  assign dctl[0] = dctl_in_q;
  assign drem[0] = drem_in_q;
  assign dquo[0] = '0;

  // divider chain, most significant quotient bit first
  for (genvar k = 0; k < QB; k++) begin : g_div
    e2q_div_cell #(.NW(NW), .QB(QB), .J(QB - 1 - k)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .ctl_i (dctl[k]),
      .rem_i (drem[k]),
      .quo_i (dquo[k]),
      .ctl_o (dctl[k+1]),
      .rem_o (drem[k+1]),
      .quo_o (dquo[k+1])
    );
  end

  // saturate to one, restore sign, zero norm gives zero
  localparam logic [QB-1:0] LIM = QB'(1) << OUT_FRAC_BITS;
  logic [QB-1:0]        qsat_w [4];
  logic signed [OW-1:0] res_w [4];
  logic signed [OW-1:0] out_q [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (dctl[QB].ovf[l] || (dquo[QB][l] > LIM)) begin
        qsat_w[l] = LIM;
      end else begin
        qsat_w[l] = dquo[QB][l];
      end
      if (dctl[QB].zero) begin
        res_w[l] = '0;
      end else if (dctl[QB].neg[l]) begin
        res_w[l] = -$signed(OW'(qsat_w[l]));
      end else begin
        res_w[l] = $signed(OW'(qsat_w[l]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[NV-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        out_q[l] <= res_w[l];
      end
    end
  end

  assign quat_o.valid = out_vld_q;
  assign quat_o.scalar_part = out_q[0];
  assign quat_o.vec_first = out_q[1];
  assign quat_o.vec_second = out_q[2];
  assign quat_o.vec_third = out_q[3];
endmodule
`default_nettype wire
